// ===== design/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared field widths and limits for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

	localparam int CENTER_W    = 11;
	localparam int RADIUS_W    = 6;
	localparam int MAX_RESULTS = 48;
	localparam int MAX_ITER    = MAX_RESULTS / 2;

	typedef logic signed [CENTER_W-1:0] center_t;
	typedef logic        [RADIUS_W-1:0] radius_t;

endpackage

// ===== design/mcr_if.sv =====
// ----------------------------------------------------------------------------
// mcr channel interfaces
// Circle command channel and point result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcr_cmd_if;
	import mcr_pkg::*;

	logic    valid;
	logic    ready;
	center_t center_col;
	center_t center_row;
	radius_t circle_radius;

	modport source (output valid, output center_col, output center_row,
		output circle_radius, input ready);
	modport sink (input valid, input center_col, input center_row,
		input circle_radius, output ready);
endinterface

interface mcr_pts_if #(
	parameter int COORD_BITS = 12
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pt0_col;
	logic signed [COORD_BITS-1:0] pt0_row;
	logic signed [COORD_BITS-1:0] pt1_col;
	logic signed [COORD_BITS-1:0] pt1_row;
	logic signed [COORD_BITS-1:0] pt2_col;
	logic signed [COORD_BITS-1:0] pt2_row;
	logic signed [COORD_BITS-1:0] pt3_col;
	logic signed [COORD_BITS-1:0] pt3_row;
	logic                         lower_half;
	logic                         final_item;

	modport source (output valid, output pt0_col, output pt0_row, output pt1_col,
		output pt1_row, output pt2_col, output pt2_row, output pt3_col,
		output pt3_row, output lower_half, output final_item, input ready);
	modport sink (input valid, input pt0_col, input pt0_row, input pt1_col,
		input pt1_row, input pt2_col, input pt2_row, input pt3_col,
		input pt3_row, input lower_half, input final_item, output ready);
endinterface

// ===== design/midpoint_circle_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle walk: one command in, a run of mirrored point items out.
// ----------------------------------------------------------------------------
// usage
//   cmd: one item per circle (center_col, center_row, circle_radius).
//   pts: two items per walk iteration, four mirrored points each; lower_half
//        tells the halves apart and final_item marks the last item of a circle.
//   cmd.ready is low from the cycle after a nonzero-radius command is taken
//   until the last item of that circle is loaded into the output register.
//   the first item is loaded into the output register once the walk state is
//   entered; after that one item per cycle while pts.ready is high, 2*N items
//   per circle, N being the iteration count (about 0.71*radius + 1, capped at
//   24), and the next command is taken once the block is back in idle.
//   the rate is set by the single walk-update and mirror unit, which serves
//   one item a cycle while pts does not stall.
//   a radius of zero is taken and gives nothing; radii above
//   MAX_RADIUS are clamped to it.
//   when pts stalls, the item holds in the output register and the walk waits.
//   reset (arst_n low) drops both valid and busy, the block comes up idle.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer #(
	parameter int MAX_RADIUS = 32,
	parameter int COORD_BITS = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	mcr_cmd_if.sink   cmd,
	mcr_pts_if.source pts
);
	import mcr_pkg::*;

	localparam int XW     = $clog2(MAX_RADIUS + 1) + 1;
	localparam int EW     = $clog2(4 * MAX_RADIUS + 2 * MAX_ITER + 8) + 2;
	localparam int IW     = $clog2(MAX_ITER);
	localparam int WIDE_W = 17;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	localparam radius_t          RMAX     = RADIUS_W'(MAX_RADIUS);
	localparam logic [IW-1:0]    LAST_IT  = IW'(MAX_ITER - 1);

	logic                  state_q;
	logic                  half_q;
	logic [IW-1:0]         iter_q;
	logic signed [XW-1:0]  x_q, y_q;
	logic signed [EW-1:0]  dx_q, dy_q, err_q;
	logic signed [EW-1:0]  two_r_q;
	center_t               cx_q, cy_q;

	logic                  ov_q;
	logic signed [COORD_BITS-1:0] p0c_q, p0r_q, p1c_q, p1r_q;
	logic signed [COORD_BITS-1:0] p2c_q, p2r_q, p3c_q, p3r_q;
	logic                  lh_q, fin_q;

	radius_t r_sat;
	logic    cmd_take, load_en;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_take  = cmd.valid && cmd.ready;
	assign r_sat     = (cmd.circle_radius > RMAX) ? RMAX : cmd.circle_radius;
	assign load_en   = (state_q == ST_WALK) && (!ov_q || pts.ready);

	// walk update unit
	logic                 adv_y, adv_x;
	logic signed [EW-1:0] err1, err2, dx2;
	logic signed [XW-1:0] x_n, y_n;
	logic                 last_res;

	always_comb begin
		adv_y = (err_q <= 0);
		err1  = adv_y ? err_q + dy_q : err_q;
		y_n   = adv_y ? y_q + XW'(1) : y_q;
		adv_x = (err1 > 0);
		dx2   = dx_q + EW'(2);
		err2  = adv_x ? err1 + dx2 - two_r_q : err1;
		x_n   = adv_x ? x_q - XW'(1) : x_q;
		last_res = half_q && ((iter_q == LAST_IT) || (x_n < y_n));
	end

	// mirror unit: the sign flips between the two halves
	logic signed [WIDE_W-1:0] cxw, cyw, xw, yw, xm, ym;
	logic signed [WIDE_W-1:0] c_px, c_mx, c_py, c_my, r_py, r_px;

	always_comb begin
		cxw  = {{(WIDE_W-CENTER_W){cx_q[CENTER_W-1]}}, cx_q};
		cyw  = {{(WIDE_W-CENTER_W){cy_q[CENTER_W-1]}}, cy_q};
		xw   = {{(WIDE_W-XW){x_q[XW-1]}}, x_q};
		yw   = {{(WIDE_W-XW){y_q[XW-1]}}, y_q};
		xm   = half_q ? -xw : xw;
		ym   = half_q ? -yw : yw;
		c_px = cxw + xm;
		c_mx = cxw - xm;
		c_py = cxw + ym;
		c_my = cxw - ym;
		r_py = cyw + ym;
		r_px = cyw + xm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			half_q  <= 1'b0;
			iter_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take && (r_sat != '0)) begin
						state_q <= ST_WALK;
						half_q  <= 1'b0;
						iter_q  <= '0;
					end
				end
				ST_WALK: begin
					if (load_en) begin
						half_q <= !half_q;
						if (half_q) begin
							iter_q <= iter_q + IW'(1);
						end
						if (last_res) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_en) begin
				ov_q <= 1'b1;
			end else if (pts.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cx_q    <= cmd.center_col;
			cy_q    <= cmd.center_row;
			two_r_q <= EW'(r_sat) <<< 1;
			x_q     <= XW'(r_sat) - XW'(1);
			y_q     <= '0;
			dx_q    <= EW'(1);
			dy_q    <= EW'(1);
			err_q   <= EW'(1) - (EW'(r_sat) <<< 1);
		end else if (load_en && half_q) begin
			x_q   <= x_n;
			y_q   <= y_n;
			err_q <= err2;
			if (adv_y) begin
				dy_q <= dy_q + EW'(2);
			end
			if (adv_x) begin
				dx_q <= dx2;
			end
		end
		if (load_en) begin
			p0c_q <= c_px[COORD_BITS-1:0];
			p0r_q <= r_py[COORD_BITS-1:0];
			p1c_q <= c_py[COORD_BITS-1:0];
			p1r_q <= r_px[COORD_BITS-1:0];
			p2c_q <= c_my[COORD_BITS-1:0];
			p2r_q <= r_px[COORD_BITS-1:0];
			p3c_q <= c_mx[COORD_BITS-1:0];
			p3r_q <= r_py[COORD_BITS-1:0];
			lh_q  <= half_q;
			fin_q <= last_res;
		end
	end

	assign pts.valid      = ov_q;
	assign pts.pt0_col    = p0c_q;
	assign pts.pt0_row    = p0r_q;
	assign pts.pt1_col    = p1c_q;
	assign pts.pt1_row    = p1r_q;
	assign pts.pt2_col    = p2c_q;
	assign pts.pt2_row    = p2r_q;
	assign pts.pt3_col    = p3c_q;
	assign pts.pt3_row    = p3r_q;
	assign pts.lower_half = lh_q;
	assign pts.final_item = fin_q;

endmodule

// ===== design/mcr_checker.sv =====
// ----------------------------------------------------------------------------
// mcr_checker
// Port-level checks for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
module mcr_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic cmd_nonzero,
	input logic pts_valid,
	input logic pts_ready,
	input logic pts_lower,
	input logic pts_final
);

	// a nonzero-radius command keeps the block busy
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_nonzero |=> !cmd_ready)
		else $error("command taken while previous circle still walking");

	// more items of the circle still to come
	a_busy_until_final: assert property (@(posedge clk) disable iff (!arst_n)
		pts_valid && pts_ready && !pts_final |-> !cmd_ready)
		else $error("idle before final item");

	// second half follows the first without a gap
	a_half_pair: assert property (@(posedge clk) disable iff (!arst_n)
		pts_valid && pts_ready && !pts_lower |=> pts_valid && pts_lower)
		else $error("second half item missing");

	a_final_on_lower: assert property (@(posedge clk) disable iff (!arst_n)
		pts_valid && pts_final |-> pts_lower)
		else $error("final item on first half");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pts_valid && !pts_ready |=> pts_valid)
		else $error("item dropped under stall");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_nonzero (cmd.circle_radius != '0),
	.pts_valid   (pts.valid),
	.pts_ready   (pts.ready),
	.pts_lower   (pts.lower_half),
	.pts_final   (pts.final_item)
);

// ===== verif/circle_point_checker.sv =====
// ----------------------------------------------------------------------------
// circle_point_checker
// Watches the command and point channels of the rasterizer. Each accepted
// circle command is walked here to build the point items it should give, and
// each accepted point item is compared against the oldest of those, field by
// field. The mismatch count and the number of items still due go to the top.
// ----------------------------------------------------------------------------
module circle_point_checker (
	input  logic clk,
	input  logic arst_n,
	mcr_cmd_if   cmd,
	mcr_pts_if   pts,
	output int   fail_count,
	output int   outstanding
);
	import mcr_pkg::*;

	localparam int COORD_W    = 12;
	localparam int RADIUS_CAP = 32;
	localparam int PRINT_CAP  = 40;

	// coord[2k] is the column and coord[2k+1] the row of point k
	typedef struct packed {
		logic [7:0][COORD_W-1:0] coord;
		logic                    lower_half;
		logic                    final_item;
	} point_item_t;

	point_item_t pending_points[$];
	int          mismatches = 0;
	string       coord_name[8] = '{"pt0_col", "pt0_row", "pt1_col", "pt1_row",
		"pt2_col", "pt2_row", "pt3_col", "pt3_row"};

	assign fail_count = mismatches;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	// full midpoint walk for one circle, queued as the items it should produce
	function automatic void trace_circle(input int cx, input int cy, input int rad);
		int          x;
		int          y;
		int          dx;
		int          dy;
		int          err;
		int          emitted;
		point_item_t upper;
		point_item_t lower;
		point_item_t last;

		if (rad > RADIUS_CAP) begin
			rad = RADIUS_CAP;
		end
		x = rad - 1;
		y = 0;
		dx = 1;
		dy = 1;
		err = dx - 2 * rad;
		emitted = 0;
		while (x >= y && emitted + 2 <= MAX_RESULTS) begin
			upper.coord[0] = COORD_W'(cx + x);
			upper.coord[1] = COORD_W'(cy + y);
			upper.coord[2] = COORD_W'(cx + y);
			upper.coord[3] = COORD_W'(cy + x);
			upper.coord[4] = COORD_W'(cx - y);
			upper.coord[5] = COORD_W'(cy + x);
			upper.coord[6] = COORD_W'(cx - x);
			upper.coord[7] = COORD_W'(cy + y);
			upper.lower_half = 1'b0;
			upper.final_item = 1'b0;
			lower.coord[0] = COORD_W'(cx - x);
			lower.coord[1] = COORD_W'(cy - y);
			lower.coord[2] = COORD_W'(cx - y);
			lower.coord[3] = COORD_W'(cy - x);
			lower.coord[4] = COORD_W'(cx + y);
			lower.coord[5] = COORD_W'(cy - x);
			lower.coord[6] = COORD_W'(cx + x);
			lower.coord[7] = COORD_W'(cy - y);
			lower.lower_half = 1'b1;
			lower.final_item = 1'b0;
			pending_points.push_back(upper);
			pending_points.push_back(lower);
			emitted += 2;

			if (err <= 0) begin
				y++;
				err += dy;
				dy += 2;
			end
			if (err > 0) begin
				x--;
				dx += 2;
				err += dx - 2 * rad;
			end
		end
		if (emitted > 0) begin
			last = pending_points.pop_back();
			last.final_item = 1'b1;
			pending_points.push_back(last);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		point_item_t seen;
		point_item_t want;

		if (!arst_n) begin
			pending_points.delete();
			outstanding <= 0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				trace_circle(int'(cmd.center_col), int'(cmd.center_row),
					int'(cmd.circle_radius));
			end
			if (pts.valid && pts.ready) begin
				seen.coord = {pts.pt3_row, pts.pt3_col, pts.pt2_row, pts.pt2_col,
					pts.pt1_row, pts.pt1_col, pts.pt0_row, pts.pt0_col};
				seen.lower_half = pts.lower_half;
				seen.final_item = pts.final_item;
				if (pending_points.size() == 0) begin
					report_mismatch($sformatf("point item with no circle pending: %h",
						seen));
				end else begin
					want = pending_points.pop_front();
					for (int k = 0; k < 8; k++) begin
						if (seen.coord[k] !== want.coord[k]) begin
							report_mismatch($sformatf("%s got %0d expected %0d",
								coord_name[k], $signed(seen.coord[k]),
								$signed(want.coord[k])));
						end
					end
					if (seen.lower_half !== want.lower_half) begin
						report_mismatch($sformatf("lower_half got %b expected %b",
							seen.lower_half, want.lower_half));
					end
					if (seen.final_item !== want.final_item) begin
						report_mismatch($sformatf("final_item got %b expected %b",
							seen.final_item, want.final_item));
					end
				end
			end
			outstanding <= pending_points.size();
		end
	end

endmodule

// ===== verif/midpoint_circle_rasterizer_test.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_test
// Drives circle commands into the rasterizer: a directed set of corner
// centers and radii (zero, tiny, full, clamped), then random circles. Both
// channels idle and stall at random, with calm stretches. The checker does
// the predicting; this top gives the verdict once every item has drained.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_test;
	import mcr_pkg::*;

	localparam int RANDOM_CIRCLES = 131;
	localparam int DRAIN_CYCLES   = 64;
	localparam int NUM_DIRECTED   = 19;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   send_calm = 0;
	int   recv_calm = 0;
	int   stall;

	int dir_col[NUM_DIRECTED] = '{0, 0, 0, 0, 5, -1024, 1023, -1024, 1023, 0,
		-1, 100, 0, 17, -1024, 1023, -5, 0, -300};
	int dir_row[NUM_DIRECTED] = '{0, 0, 0, 0, -7, -1024, 1023, 1023, -1024, 0,
		-1, -200, 0, 23, 1023, -1024, 9, -1, 300};
	int dir_rad[NUM_DIRECTED] = '{0, 1, 2, 3, 4, 32, 32, 33, 63, 63,
		0, 0, 10, 31, 1, 1, 32, 45, 16};

	mcr_cmd_if cmd ();
	mcr_pts_if #(.COORD_BITS(12)) pts ();

	midpoint_circle_rasterizer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pts    (pts)
	);

	circle_point_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.pts         (pts),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	// idle cycles before the next item, with occasional runs of none at all
	function automatic int draw_gap(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm = $urandom_range(4, 24);
		end
		return $urandom_range(0, 15);
	endfunction

	task automatic send_circle(input int col, input int row, input int rad);
		int gap;

		gap = draw_gap(send_calm);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid         <= 1'b1;
		cmd.center_col    <= center_t'(col);
		cmd.center_row    <= center_t'(row);
		cmd.circle_radius <= radius_t'(rad);
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
	endtask

	initial begin
		arst_n            = 1'b0;
		cmd.valid         = 1'b0;
		cmd.center_col    = '0;
		cmd.center_row    = '0;
		cmd.circle_radius = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < NUM_DIRECTED; k++) begin
			send_circle(dir_col[k], dir_row[k], dir_rad[k]);
		end

		// mostly in-range radii, some zero, some above the clamp
		for (int k = 0; k < RANDOM_CIRCLES; k++) begin
			case ($urandom_range(0, 9))
				0: send_circle($urandom_range(0, 2047) - 1024,
					$urandom_range(0, 2047) - 1024, 0);
				1: send_circle($urandom_range(0, 2047) - 1024,
					$urandom_range(0, 2047) - 1024, $urandom_range(33, 63));
				default: send_circle($urandom_range(0, 2047) - 1024,
					$urandom_range(0, 2047) - 1024, $urandom_range(1, 32));
			endcase
		end
		cmd.valid <= 1'b0;

		// the count seen here is registered, so let the last command land first
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// point sink: a random stall before each item is taken
	initial begin
		pts.ready = 1'b0;
		forever begin
			stall = draw_gap(recv_calm);
			if (stall > 0) begin
				pts.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pts.ready <= 1'b1;
			@(posedge clk);
			while (!pts.valid) @(posedge clk);
		end
	end

	initial begin
		#(8 * 1000000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
design/mcr_pkg.sv
design/mcr_if.sv
design/midpoint_circle_rasterizer.sv
design/mcr_checker.sv
verif/circle_point_checker.sv
verif/midpoint_circle_rasterizer_test.sv
